// ===== rtl/hse_pkg.sv =====
// Package for the harmonic spring energy and force block.
// Holds widths, limits, the queue entry types and the back-end state codes.
// No dependencies; the modules of the block and the testbench import it.
package hse_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int COORD_W  = 32;
	localparam int FORCE_W  = 48;
	localparam int ENERGY_W = 63;
	localparam int SUM_W    = 64;
	localparam int LEN_W    = 35;
	localparam int SUMSQ_W  = 66;
	localparam int SQOP_W   = 70;
	localparam int SREM_W   = 37;
	localparam int SABS_W   = 33;
	localparam int KS_W     = 65;
	localparam int MA_W     = 66;
	localparam int MB_W     = 33;
	localparam int PW       = 99;
	localparam int CNT_W    = 7;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX    = '1;
	localparam logic [FORCE_W-1:0]  FORCE_POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [FORCE_W-1:0]  FORCE_NEG_LIM = 48'h8000_0000_0000;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] dabs;
		logic [2:0]              dneg;
		logic [COORD_W-1:0]      stiffness;
		logic [COORD_W-1:0]      rest_length;
		logic                    last;
		logic                    zero_len;
	} spring_entry_t;

	typedef struct packed {
		logic          valid;
		spring_entry_t entry;
	} queue_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQRT,
		ST_SABS,
		ST_MUL_SQ,
		ST_MUL_EK,
		ST_MUL_KS,
		ST_MUL_NUM,
		ST_DIV,
		ST_FORCE,
		ST_FINISH
	} back_state_t;

endpackage

// ===== rtl/hse_in_if.sv =====
// Request channel carrying one spring: two bead positions, stiffness, rest length.
// Standalone interface with valid/ready handshake; no dependencies.
interface hse_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;
	logic [31:0]        stiffness;
	logic [31:0]        rest_length;
	logic               last_spring;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		stiffness, rest_length, last_spring, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		stiffness, rest_length, last_spring, output ready);
endinterface

// ===== rtl/hse_out_if.sv =====
// Result channel: per-spring energy, force on the second bead, running total and flags.
// Standalone interface with valid/ready handshake; no dependencies.
interface hse_out_if;
	logic               valid;
	logic               ready;
	logic [62:0]        spring_energy;
	logic signed [47:0] force_x;
	logic signed [47:0] force_y;
	logic signed [47:0] force_z;
	logic [62:0]        total_energy;
	logic               error_flag;
	logic               is_last;

	modport source (output valid, spring_energy, force_x, force_y, force_z, total_energy,
		error_flag, is_last, input ready);
	modport sink (input valid, spring_energy, force_x, force_y, force_z, total_energy,
		error_flag, is_last, output ready);
endinterface

// ===== rtl/harmonic_spring_energy_force.sv =====
// Top level of the harmonic spring energy and force block.
// Depends on hse_pkg, hse_in_if, hse_out_if, hse_front, hse_fifo and hse_back.

// Each request describes one spring: two bead positions, a stiffness k and a
// rest length r, all with FRAC_BITS fraction bits. The result gives the spring
// energy 0.5*k*(L-r)^2 (2*FRAC_BITS fraction bits), the force on the second
// bead k*(L-r)/L*(p1-p2) (the first bead takes its negation), the running
// energy total and a sticky error flag; both are cleared after the spring
// marked last. Coincident beads give zero force and raise the error flag, as
// does any saturated energy, force or total. The front end is combinational
// and places each request in a short queue, so requests keep arriving
// while the back end works. The back end handles one spring at a time on a
// shared bit-serial multiplier, a two-bit-per-step square root and a
// one-bit-per-step divider. Per spring it runs three 33-step squares, a
// 35-step root, three 33-step products for the energy and k*(L-r), then per
// axis a 33-step product and a 99-step division, plus control steps: the
// pop, the |L-r| step, one force step per axis and the hand-off to the output
// register; coincident beads skip the force work. The finished result sits in
// an output register while the next spring starts; a result that is still
// unaccepted when the next one finishes holds the back end in its hand-off
// state.
module harmonic_spring_energy_force import hse_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hse_in_if.sink    springs,
	hse_out_if.source results
);

	spring_entry_t push_entry;
	logic          push_valid;
	logic          push_ready;
	queue_head_t   head;
	logic          pop;

	// Differences, magnitudes and the coincident-bead class are formed here.
	hse_front u_front (
		.springs    (springs),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decouples request acceptance from the long per-spring computation.
	hse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// Sequential arithmetic, saturation and the running total.
	hse_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

// ===== rtl/hse_front.sv =====
// Front end: takes spring requests, forms coordinate differences and classifies coincident beads.
// Depends on hse_pkg and hse_in_if.
module hse_front import hse_pkg::*; (
	hse_in_if.sink        springs,
	output spring_entry_t push_entry,
	output logic          push_valid,
	input  logic          push_ready
);

	logic signed [COORD_W:0] diff [3];
	logic [COORD_W-1:0]      first_c [3];
	logic [COORD_W-1:0]      second_c [3];

	assign first_c[0]  = springs.first_x;
	assign first_c[1]  = springs.first_y;
	assign first_c[2]  = springs.first_z;
	assign second_c[0] = springs.second_x;
	assign second_c[1] = springs.second_y;
	assign second_c[2] = springs.second_z;

	always_comb begin
		logic [COORD_W:0] mag;
		push_entry = '0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({first_c[i][COORD_W-1], first_c[i]})
				- $signed({second_c[i][COORD_W-1], second_c[i]});
			mag = diff[i][COORD_W] ? ((COORD_W+1)'(0) - diff[i]) : diff[i];
			push_entry.dabs[i] = mag[COORD_W-1:0];
			push_entry.dneg[i] = diff[i][COORD_W];
		end
		push_entry.stiffness   = springs.stiffness;
		push_entry.rest_length = springs.rest_length;
		push_entry.last        = springs.last_spring;
		// Coincident beads give a zero length, which the back end treats specially.
		push_entry.zero_len    = (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
	end

	assign push_valid    = springs.valid;
	assign springs.ready = push_ready;

endmodule

// ===== rtl/hse_fifo.sv =====
// Short queue of classified springs between the front and back ends.
// Depends on hse_pkg.
module hse_fifo import hse_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spring_entry_t push_entry,
	input  logic          push_valid,
	output logic          push_ready,
	output queue_head_t   head,
	input  logic          pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	spring_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign push       = push_valid && push_ready;
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a push");

endmodule

// ===== rtl/hse_back.sv =====
// Back end: bit-serial square root, multiplies and division per spring, then saturation
// and the running energy total. Depends on hse_pkg and hse_out_if.
module hse_back import hse_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	hse_out_if.source   results
);

	localparam int DIV_W = LEN_W + FRAC_BITS;
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MB_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(LEN_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PW - 1);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              axis_q;
	spring_entry_t           ent_q;
	logic [MA_W-1:0]         mul_a_q;
	logic [MB_W-1:0]         mul_b_q;
	logic [PW-1:0]           p_q;
	logic [SUMSQ_W-1:0]      sumsq_q;
	logic [SQOP_W-1:0]       sq_q;
	logic [LEN_W-1:0]        root_q;
	logic [SREM_W-1:0]       srem_q;
	logic [DIV_W-1:0]        drem_q;
	logic                    sneg_q;
	logic [SABS_W-1:0]       sabs_q;
	logic [ENERGY_W-1:0]     energy_q;
	logic [KS_W-1:0]         ks_q;
	logic [2:0][FORCE_W-1:0] force_q;
	logic                    err_q;
	logic [SUM_W-1:0]        energy_sum_q;
	logic                    error_seen_q;
	logic                    out_valid_q;
	logic [ENERGY_W-1:0]     out_energy_q, out_total_q;
	logic [2:0][FORCE_W-1:0] out_force_q;
	logic                    out_err_q, out_last_q;

	logic               cnt_done, finish;
	logic [PW-1:0]      mul_step;
	logic [SUMSQ_W-1:0] sumsq_next;
	logic [SREM_W+1:0]  s_t, s_trial, s_diff;
	logic               s_ge;
	logic [DIV_W-1:0]   divisor;
	logic [DIV_W:0]     d_t, d_diff;
	logic               d_ge;
	logic [PW-1:0]      e_wide;
	logic               e_sat;
	logic               sneg_c;
	logic [LEN_W-1:0]   sabs_wide;
	logic               f_neg, f_over;
	logic [FORCE_W-1:0] f_lim, f_mag, f_val;
	logic [SUM_W:0]     t_sum;
	logic               t_sat;
	logic               err_all;

	assign cnt_done = (state_q == ST_SQRT) ? (cnt_q == SQRT_LAST) :
		(state_q == ST_DIV) ? (cnt_q == DIV_LAST) : (cnt_q == MUL_LAST);

	// Shift-and-add multiplier, multiplier bits taken MSB first.
	assign mul_step   = (p_q << 1) + (mul_b_q[MB_W-1] ? PW'(mul_a_q) : PW'(0));
	assign sumsq_next = sumsq_q + mul_step[SUMSQ_W-1:0];

	// Digit-by-digit square root, two operand bits per step.
	assign s_t     = {srem_q, sq_q[SQOP_W-1 -: 2]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_ge    = (s_t >= s_trial);
	assign s_diff  = s_t - s_trial;

	// Restoring division of the numerator in p_q by L scaled to the fraction width.
	assign divisor = {root_q, {FRAC_BITS{1'b0}}};
	assign d_t     = {drem_q, p_q[PW-1]};
	assign d_ge    = (d_t >= {1'b0, divisor});
	assign d_diff  = d_t - {1'b0, divisor};

	assign e_wide = mul_step >> (FRAC_BITS + 1);
	assign e_sat  = |e_wide[PW-1:ENERGY_W];

	assign sneg_c    = (root_q < LEN_W'(ent_q.rest_length));
	assign sabs_wide = sneg_c ? (LEN_W'(ent_q.rest_length) - root_q)
		: (root_q - LEN_W'(ent_q.rest_length));

	assign f_neg  = ent_q.dneg[axis_q] ^ sneg_q;
	assign f_lim  = f_neg ? FORCE_NEG_LIM : FORCE_POS_LIM;
	assign f_over = (|p_q[PW-1:FORCE_W]) || (p_q[FORCE_W-1:0] > f_lim);
	assign f_mag  = f_over ? f_lim : p_q[FORCE_W-1:0];
	assign f_val  = f_neg ? (FORCE_W'(0) - f_mag) : f_mag;

	assign t_sum   = {1'b0, energy_sum_q} + (SUM_W+1)'(energy_q);
	assign t_sat   = (t_sum > (SUM_W+1)'(ENERGY_MAX));
	assign err_all = error_seen_q || err_q || t_sat;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE:  if (cnt_done && axis_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT:    if (cnt_done) state_d = ST_SABS;
			ST_SABS:    state_d = ST_MUL_SQ;
			ST_MUL_SQ:  if (cnt_done) state_d = ST_MUL_EK;
			ST_MUL_EK:  if (cnt_done) state_d = ST_MUL_KS;
			ST_MUL_KS:  if (cnt_done) state_d = ent_q.zero_len ? ST_FINISH : ST_MUL_NUM;
			ST_MUL_NUM: if (cnt_done) state_d = ST_DIV;
			ST_DIV:     if (cnt_done) state_d = ST_FORCE;
			ST_FORCE:   state_d = (axis_q == 2'd2) ? ST_FINISH : ST_MUL_NUM;
			ST_FINISH: begin
				if (!out_valid_q || results.ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q   <= cnt_q + CNT_W'(1);
		p_q     <= mul_step;
		mul_b_q <= mul_b_q << 1;
		unique case (state_q)
			ST_IDLE: begin
				ent_q   <= head.entry;
				axis_q  <= 2'd0;
				cnt_q   <= '0;
				p_q     <= '0;
				mul_a_q <= MA_W'(head.entry.dabs[0]);
				mul_b_q <= MB_W'(head.entry.dabs[0]);
				sumsq_q <= '0;
				err_q   <= 1'b0;
			end
			ST_SQUARE: begin
				if (cnt_done) begin
					sumsq_q <= sumsq_next;
					cnt_q   <= '0;
					p_q     <= '0;
					axis_q  <= axis_q + 2'd1;
					mul_a_q <= MA_W'(ent_q.dabs[axis_q + 2'd1]);
					mul_b_q <= MB_W'(ent_q.dabs[axis_q + 2'd1]);
					sq_q    <= SQOP_W'(sumsq_next);
					root_q  <= '0;
					srem_q  <= '0;
				end
			end
			ST_SQRT: begin
				sq_q   <= sq_q << 2;
				root_q <= {root_q[LEN_W-2:0], s_ge};
				srem_q <= s_ge ? s_diff[SREM_W-1:0] : s_t[SREM_W-1:0];
			end
			ST_SABS: begin
				sneg_q  <= sneg_c;
				sabs_q  <= sabs_wide[SABS_W-1:0];
				cnt_q   <= '0;
				p_q     <= '0;
				mul_a_q <= MA_W'(sabs_wide[SABS_W-1:0]);
				mul_b_q <= sabs_wide[SABS_W-1:0];
			end
			ST_MUL_SQ: begin
				if (cnt_done) begin
					cnt_q   <= '0;
					p_q     <= '0;
					mul_a_q <= mul_step[MA_W-1:0];
					mul_b_q <= MB_W'(ent_q.stiffness);
				end
			end
			ST_MUL_EK: begin
				if (cnt_done) begin
					energy_q <= e_sat ? ENERGY_MAX : e_wide[ENERGY_W-1:0];
					err_q    <= err_q || e_sat;
					cnt_q    <= '0;
					p_q      <= '0;
					mul_a_q  <= MA_W'(sabs_q);
					mul_b_q  <= MB_W'(ent_q.stiffness);
				end
			end
			ST_MUL_KS: begin
				if (cnt_done) begin
					ks_q    <= mul_step[KS_W-1:0];
					axis_q  <= 2'd0;
					cnt_q   <= '0;
					p_q     <= '0;
					mul_a_q <= MA_W'(mul_step[KS_W-1:0]);
					mul_b_q <= MB_W'(ent_q.dabs[0]);
					if (ent_q.zero_len) begin
						force_q <= '0;
						err_q   <= 1'b1;
					end
				end
			end
			ST_MUL_NUM: begin
				if (cnt_done) begin
					cnt_q  <= '0;
					drem_q <= '0;
				end
			end
			ST_DIV: begin
				p_q    <= {p_q[PW-2:0], d_ge};
				drem_q <= d_ge ? d_diff[DIV_W-1:0] : d_t[DIV_W-1:0];
			end
			ST_FORCE: begin
				force_q[axis_q] <= f_val;
				err_q           <= err_q || f_over;
				axis_q          <= axis_q + 2'd1;
				cnt_q           <= '0;
				p_q             <= '0;
				mul_a_q         <= MA_W'(ks_q);
				mul_b_q         <= MB_W'(ent_q.dabs[axis_q + 2'd1]);
			end
			ST_FINISH: begin
				if (finish) begin
					out_energy_q <= energy_q;
					out_force_q  <= force_q;
					out_total_q  <= t_sat ? ENERGY_MAX : t_sum[ENERGY_W-1:0];
					out_err_q    <= err_all;
					out_last_q   <= ent_q.last;
				end
			end
			default: cnt_q <= '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			energy_sum_q <= '0;
			error_seen_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				if (ent_q.last) begin
					energy_sum_q <= '0;
					error_seen_q <= 1'b0;
				end else begin
					energy_sum_q <= t_sat ? SUM_W'(ENERGY_MAX) : t_sum[SUM_W-1:0];
					error_seen_q <= err_all;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.spring_energy = out_energy_q;
	assign results.force_x       = out_force_q[0];
	assign results.force_y       = out_force_q[1];
	assign results.force_z       = out_force_q[2];
	assign results.total_energy  = out_total_q;
	assign results.error_flag    = out_err_q;
	assign results.is_last       = out_last_q;

endmodule

// ===== tb/sv/harmonic_spring_energy_force_tb.sv =====
// Self-checking testbench for the harmonic spring energy and force block.
// Depends on hse_pkg, hse_in_if, hse_out_if and harmonic_spring_energy_force.
// Directed springs and then random springs are sent, and every result is checked against a local predictor.
module harmonic_spring_energy_force_tb;
	import hse_pkg::*;

	localparam int     FRAC        = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam int     DRAIN_WAIT  = 1200;
	localparam int     RANDOM_ITEMS = 1650;

	// One spring request as the sender drives it.
	typedef struct {
		logic signed [31:0] p1 [3];
		logic signed [31:0] p2 [3];
		logic [31:0]        k;
		logic [31:0]        rest;
		logic               last;
	} spring_t;

	// One expected result, in the widths of the result channel.
	typedef struct {
		logic [62:0] energy;
		logic [47:0] frc [3];
		logic [62:0] total;
		logic        err;
		logic        last;
	} spring_result_t;

	logic   clk;
	logic   arst_n;
	longint cycle_count;
	int     mismatch_count;
	int     burst_left;

	// Running total and sticky error of the current set, as the block should hold them.
	logic [63:0] set_energy_sum;
	logic        set_error_seen;

	spring_result_t pending_results [$];

	hse_in_if  springs ();
	hse_out_if results ();

	harmonic_spring_energy_force dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.springs (springs.sink),
		.results (results.source)
	);

	// The clock runs from time zero with a period of four units.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The cycle counter also acts as the watchdog for a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Works out the result of one spring and advances the set state. The distance is
	// the integer square root of the exact sum of squares; energy and force are formed
	// at full width before saturation, so 128 bits hold every intermediate value.
	function automatic spring_result_t predict_spring(input spring_t s);
		spring_result_t r;
		logic [127:0] sumsq, cand, len, sabs, wide, ks, q, lim;
		logic [32:0]  dabs [3];
		logic         dneg [3];
		logic signed [32:0] diff;
		logic         sneg, err, neg;
		logic [63:0]  energy, total;
		sumsq = '0;
		err = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff = 33'(s.p1[i]) - 33'(s.p2[i]);
			dneg[i] = diff < 0;
			dabs[i] = dneg[i] ? 33'(-diff) : 33'(diff);
			sumsq += 128'(dabs[i]) * 128'(dabs[i]);
		end
		len = '0;
		for (int b = 34; b >= 0; b--) begin
			cand = len | (128'd1 << b);
			if (cand * cand <= sumsq)
				len = cand;
		end
		sneg = len < 128'(s.rest);
		sabs = sneg ? 128'(s.rest) - len : len - 128'(s.rest);

		wide = (sabs * sabs * 128'(s.k)) >> (FRAC + 1);
		if (wide > 128'(ENERGY_MAX)) begin
			energy = 64'(ENERGY_MAX);
			err = 1'b1;
		end else begin
			energy = wide[63:0];
		end

		if (len == 0) begin
			// Coincident beads: no direction, so no force, but the energy still counts.
			err = 1'b1;
			for (int i = 0; i < 3; i++)
				r.frc[i] = '0;
		end else begin
			ks = 128'(s.k) * sabs;
			for (int i = 0; i < 3; i++) begin
				q = (ks * 128'(dabs[i])) / (len << FRAC);
				neg = sneg != dneg[i];
				lim = neg ? 128'(FORCE_NEG_LIM) : 128'(FORCE_POS_LIM);
				if (q > lim) begin
					q = lim;
					err = 1'b1;
				end
				r.frc[i] = neg ? 48'(-q) : 48'(q);
			end
		end

		total = set_energy_sum + energy;
		if (total > 64'(ENERGY_MAX)) begin
			total = 64'(ENERGY_MAX);
			err = 1'b1;
		end
		set_error_seen = set_error_seen | err;

		r.energy = energy[62:0];
		r.total  = total[62:0];
		r.err    = set_error_seen;
		r.last   = s.last;
		if (s.last) begin
			set_energy_sum = '0;
			set_error_seen = 1'b0;
		end else begin
			set_energy_sum = total;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Sends one request. The sender works in bursts; between bursts valid drops for a
	// random gap, which can be empty. The prediction is made at the edge where the request is accepted.
	task automatic send_spring(input spring_t s);
		int gap;
		spring_result_t expected;
		if (burst_left == 0) begin
			springs.valid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		springs.first_x     = s.p1[0];
		springs.first_y     = s.p1[1];
		springs.first_z     = s.p1[2];
		springs.second_x    = s.p2[0];
		springs.second_y    = s.p2[1];
		springs.second_z    = s.p2[2];
		springs.stiffness   = s.k;
		springs.rest_length = s.rest;
		springs.last_spring = s.last;
		springs.valid       = 1'b1;
		do
			@(posedge clk);
		while (!springs.ready);
		expected = predict_spring(s);
		pending_results.insert(pending_results.size(), expected);
		@(negedge clk);
	endtask

	// Builds a spring from explicit values; keeps the directed tests compact.
	function automatic spring_t make_spring(input logic signed [31:0] x1, y1, z1, x2, y2, z2,
		input logic [31:0] k, rest, input logic last);
		spring_t s;
		s.p1[0] = x1; s.p1[1] = y1; s.p1[2] = z1;
		s.p2[0] = x2; s.p2[1] = y2; s.p2[2] = z2;
		s.k = k; s.rest = rest; s.last = last;
		return s;
	endfunction

	// Coordinates are mostly near the origin, where springs behave like real ones,
	// with a share drawn over the full range so that every bit toggles.
	function automatic logic signed [31:0] random_coord();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		endcase
	endfunction

	function automatic logic [31:0] random_q16();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, 32'h0000_FFFF);
			default: return $urandom_range(0, 32'h0400_0000);
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [31:0] mn, mx;
		mn = 32'sh8000_0000;
		mx = 32'sh7FFF_FFFF;
		send_spring(make_spring(0, 0, 0, 32'sh0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0));
		send_spring(make_spring(mx, mx, mx, mn, mn, mn, '1, '1, 1'b0));
		send_spring(make_spring(mn, mn, mn, mx, mx, mx, '1, 0, 1'b0));
		send_spring(make_spring(mx, mn, mx, mn, mx, mn, 32'h0000_0001, '1, 1'b1));
		send_spring(make_spring(3, -4, 0, 0, 0, 0, 0, 32'h0002_0000, 1'b0));
		send_spring(make_spring(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 32'h0001_0000,
			32'h0005_0000, 1'b0));
		send_spring(make_spring(1, 0, 0, 0, 0, 0, '1, '1, 1'b1));
		send_spring(make_spring(0, 0, 1, 0, 0, 0, 32'h0001_0000, 0, 1'b1));
	endtask

	task automatic test_zero_length();
		send_spring(make_spring(5, 6, 7, 5, 6, 7, 32'h0002_0000, 32'h0001_8000, 1'b0));
		send_spring(make_spring(0, 0, 0, 0, 0, 0, '1, '1, 1'b0));
		send_spring(make_spring(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
			32'sh7FFF_FFFF, 0, 0, 1'b1));
		// The sticky flag must be clear again in the next set.
		send_spring(make_spring(0, 0, 0, 32'sh0000_8000, 0, 0, 32'h0001_0000, 0, 1'b1));
	endtask

	task automatic test_saturation();
		// Large stiffness on a long spring overflows energy, force and then the total.
		for (int i = 0; i < 4; i++)
			send_spring(make_spring(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, '1, 0, 1'b0));
		send_spring(make_spring(32'sh4000_0000, 32'sh4000_0000, 0, 0, 0, 0, '1, 1, 1'b1));
		// Force clamp in the positive direction.
		send_spring(make_spring(0, 0, 32'sh7FFF_0000, 0, 0, 32'sh8000_0000, '1,
			32'h1000_0000, 1'b0));
		// Moderate energies added to a total already saturated by the previous spring.
		for (int i = 0; i < 3; i++)
			send_spring(make_spring(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0,
				32'h0000_4000, 0, i == 2));
	endtask

	task automatic test_random();
		spring_t s;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			for (int i = 0; i < 3; i++) begin
				s.p1[i] = random_coord();
				s.p2[i] = ($urandom_range(0, 7) == 0) ? s.p1[i] : random_coord();
			end
			s.k    = random_q16();
			s.rest = random_q16();
			s.last = $urandom_range(0, 7) == 0;
			send_spring(s);
		end
	endtask

	// The receiver runs random stretches of full speed and stretches of frequent stalls.
	initial begin
		int stretch;
		bit stalling;
		results.ready = 1'b0;
		forever begin
			stalling = $urandom_range(0, 1);
			stretch  = $urandom_range(20, 3000);
			repeat (stretch) begin
				@(negedge clk);
				results.ready = stalling ? ($urandom_range(0, 3) == 0) : 1'b1;
			end
		end
	end

	// Each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		spring_result_t want;
		if (arst_n && results.valid && results.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(results.spring_energy), '0);
			end else begin
				want = pending_results.pop_front();
				if (results.spring_energy !== want.energy)
					report_mismatch("spring_energy", 64'(results.spring_energy), 64'(want.energy));
				if (results.force_x !== want.frc[0])
					report_mismatch("force_x", 64'(results.force_x), 64'(want.frc[0]));
				if (results.force_y !== want.frc[1])
					report_mismatch("force_y", 64'(results.force_y), 64'(want.frc[1]));
				if (results.force_z !== want.frc[2])
					report_mismatch("force_z", 64'(results.force_z), 64'(want.frc[2]));
				if (results.total_energy !== want.total)
					report_mismatch("total_energy", 64'(results.total_energy), 64'(want.total));
				if (results.error_flag !== want.err)
					report_mismatch("error_flag", 64'(results.error_flag), 64'(want.err));
				if (results.is_last !== want.last)
					report_mismatch("is_last", 64'(results.is_last), 64'(want.last));
			end
		end
	end

	// Main sequence: reset once, run the tests in turn, drain, then give the verdict.
	initial begin
		cycle_count    = 0;
		mismatch_count = 0;
		burst_left     = 0;
		set_energy_sum = '0;
		set_error_seen = 1'b0;
		arst_n = 1'b0;
		springs.valid = 1'b0;
		springs.first_x = '0;  springs.first_y = '0;  springs.first_z = '0;
		springs.second_x = '0; springs.second_y = '0; springs.second_z = '0;
		springs.stiffness = '0;
		springs.rest_length = '0;
		springs.last_spring = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_zero_length();
		test_saturation();
		test_random();
		springs.valid = 1'b0;

		// The watchdog bounds this wait if results stop coming.
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hse_pkg.sv
rtl/hse_in_if.sv
rtl/hse_out_if.sv
rtl/hse_front.sv
rtl/hse_fifo.sv
rtl/hse_back.sv
rtl/harmonic_spring_energy_force.sv
tb/sv/harmonic_spring_energy_force_tb.sv
